// ===== hdl/bounded_linked_list_deque_assert.svh =====
// Assertion macros for the linked list deque.
`ifndef BOUNDED_LINKED_LIST_DEQUE_ASSERT_SVH
`define BOUNDED_LINKED_LIST_DEQUE_ASSERT_SVH
`ifndef ASSERT_OFF
`define BLD_ASSERT_NEXT(label, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("label");
`define BLD_ASSERT_NOW(label, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("label");
`else
`define BLD_ASSERT_NEXT(label, rst, cond, conseq)
`define BLD_ASSERT_NOW(label, rst, cond, conseq)
`endif
`endif

// ===== hdl/bld_pkg.sv =====
// Package: types, codes and sizes of the linked list deque.
`default_nettype none
package bld_pkg;
  localparam int Capacity = 16;
  localparam int PtrW = 5;
  localparam int IdxW = 4;
  localparam int DataW = 32;
  localparam logic [PtrW-1:0] Nil = PtrW'(Capacity);

  localparam logic [3:0] FN_PUSH_FRONT = 4'd0;
  localparam logic [3:0] FN_PUSH_BACK  = 4'd1;
  localparam logic [3:0] FN_POP_FRONT  = 4'd2;
  localparam logic [3:0] FN_POP_BACK   = 4'd3;
  localparam logic [3:0] FN_PEEK_FRONT = 4'd4;
  localparam logic [3:0] FN_PEEK_BACK  = 4'd5;
  localparam logic [3:0] FN_GET        = 4'd6;
  localparam logic [3:0] FN_SET        = 4'd7;
  localparam logic [3:0] FN_INSERT     = 4'd8;
  localparam logic [3:0] FN_REMOVE_AT  = 4'd9;
  localparam logic [3:0] FN_FIND_FIRST = 4'd10;
  localparam logic [3:0] FN_FIND_LAST  = 4'd11;
  localparam logic [3:0] FN_DEL_FIRST  = 4'd12;
  localparam logic [3:0] FN_DEL_LAST   = 4'd13;
  localparam logic [3:0] FN_CLEAR      = 4'd14;
  localparam logic [3:0] FN_NOP        = 4'd15;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [3:0]              func;
    logic signed [DataW-1:0] data_value;
    logic [4:0]              position;
  } cmd_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DataW-1:0] result_value;
    logic [IdxW-1:0]         result_index;
    logic                    found;
    logic [4:0]              element_count;
  } rsp_t;

  // node store write port
  typedef struct packed {
    logic            we_val;
    logic            we_next;
    logic            we_prev;
    logic [IdxW-1:0] addr;
    logic [DataW-1:0] val;
    logic [PtrW-1:0] nxt;
    logic [PtrW-1:0] prv;
  } nwr_t;
endpackage
`default_nettype wire

// ===== hdl/bld_store.sv =====
// Node store: value, next and prev links, one read and one write a cycle.
`default_nettype none
module bld_store (
  input  wire logic                    clk,
  input  wire bld_pkg::nwr_t           wr,
  input  wire logic [bld_pkg::IdxW-1:0] raddr,
  output logic [bld_pkg::DataW-1:0]    rval,
  output logic [bld_pkg::PtrW-1:0]     rnext,
  output logic [bld_pkg::PtrW-1:0]     rprev
);
  import bld_pkg::*;
  logic [DataW-1:0] mval [Capacity];
  logic [PtrW-1:0]  mnext [Capacity];
  logic [PtrW-1:0]  mprev [Capacity];

  always_ff @(posedge clk) begin
    if (wr.we_val) mval[wr.addr] <= wr.val;
    if (wr.we_next) mnext[wr.addr] <= wr.nxt;
    if (wr.we_prev) mprev[wr.addr] <= wr.prv;
    rval <= mval[raddr];
    rnext <= mnext[raddr];
    rprev <= mprev[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/bounded_linked_list_deque.sv =====
// Top level: sequencer that walks and edits the linked list in the node store.
//
// Linked list deque of 16 signed 32-bit values. Raise start with a command
// while busy is low; busy then stays high until the result, which appears on
// the result port for one cycle with done high, in the first cycle busy is low
// again, and must be taken then. Every command passes through a decode state
// (twice for an insert at the end), and each node visited in the node store
// takes a step, a registered read and a compare (S_RD, S_WT, S_ACT): index
// walks visit up to 8 nodes from the nearer end, value searches up to 16 nodes.
`default_nettype none
module bounded_linked_list_deque (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire bld_pkg::cmd_t cmd,
  output logic               busy,
  output logic               done,
  output bld_pkg::rsp_t      rsp
);
  import bld_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_WT   = 4'd3;
  localparam logic [3:0] S_ACT  = 4'd4;
  localparam logic [3:0] S_L1   = 4'd5;
  localparam logic [3:0] S_L2   = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  logic [3:0]       state;
  cmd_t             c;
  logic [Capacity-1:0] free_map;
  logic [PtrW-1:0]  head_ptr, tail_ptr, item_count;
  logic [PtrW-1:0]  p;        // node being visited
  logic [PtrW-1:0]  idx;      // its index
  logic             back;     // walk direction
  logic             search;   // value search vs index walk
  logic [PtrW-1:0]  steps;
  logic [PtrW-1:0]  nx, pv, x;  // target node (x) and its links (nx, pv)
  logic [1:0]       mode;     // 0 read only, 1 drop, 2 insert before, 3 set
  logic [IdxW-1:0]  newn;
  rsp_t             r;
  nwr_t             wr;
  logic [IdxW-1:0]  raddr;
  logic [DataW-1:0] rval;
  logic [PtrW-1:0]  rnext, rprev;

  bld_store u_store (.clk, .wr, .raddr, .rval, .rnext, .rprev);

  // lowest free node
  always_comb begin
    newn = '0;
    for (int i = Capacity - 1; i >= 0; i--) if (free_map[i]) newn = IdxW'(i);
  end

  assign raddr = p[IdxW-1:0];
  assign busy = (state != S_IDLE);
  assign rsp = r;

  always_ff @(posedge clk) begin
    wr <= '0;
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      free_map <= '1;
      head_ptr <= Nil;
      tail_ptr <= Nil;
      item_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (start) begin
          c <= cmd;
          r <= '0;
          state <= S_DEC;
        end
        S_DEC: begin
          state <= S_OUT;
          unique case (c.func)
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
              if (item_count == PtrW'(Capacity)) r.status <= ST_FULL;
              else begin
                wr.we_val <= 1'b1; wr.we_next <= 1'b1; wr.we_prev <= 1'b1;
                wr.addr <= newn; wr.val <= c.data_value;
                free_map[newn] <= 1'b0;
                item_count <= item_count + 1'b1;
                if (c.func == FN_PUSH_FRONT) begin
                  wr.prv <= Nil; wr.nxt <= head_ptr;
                  head_ptr <= {1'b0, newn};
                  if (head_ptr == Nil) tail_ptr <= {1'b0, newn};
                  else begin x <= head_ptr; state <= S_L1; end
                end else begin
                  wr.nxt <= Nil; wr.prv <= tail_ptr;
                  tail_ptr <= {1'b0, newn};
                  if (tail_ptr == Nil) head_ptr <= {1'b0, newn};
                  else begin x <= tail_ptr; state <= S_L2; end
                end
              end
            end
            FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK: begin
              if (item_count == '0) begin
                r.status <= ST_EMPTY; r.result_value <= '1;
              end else begin
                search <= 1'b0;
                p <= (c.func == FN_POP_FRONT || c.func == FN_PEEK_FRONT)
                     ? head_ptr : tail_ptr;
                mode <= (c.func == FN_POP_FRONT || c.func == FN_POP_BACK)
                        ? 2'd1 : 2'd0;
                state <= S_WT;
              end
            end
            FN_GET, FN_SET, FN_REMOVE_AT, FN_INSERT: begin
              if ((c.func == FN_INSERT) ? (c.position > item_count)
                                        : (c.position >= item_count))
                r.status <= ST_RANGE;
              else if (c.func == FN_INSERT && item_count == PtrW'(Capacity))
                r.status <= ST_FULL;
              else if (c.func == FN_INSERT && c.position == item_count) begin
                c.func <= FN_PUSH_BACK;
                state <= S_DEC;
              end else begin
                search <= 1'b0;
                mode <= (c.func == FN_GET) ? 2'd0 : (c.func == FN_SET) ? 2'd3 :
                        (c.func == FN_INSERT) ? 2'd2 : 2'd1;
                if (c.position < (item_count >> 1)) begin
                  back <= 1'b0; p <= head_ptr; idx <= '0;
                end else begin
                  back <= 1'b1; p <= tail_ptr; idx <= item_count - 1'b1;
                end
                state <= S_RD;
              end
            end
            FN_FIND_FIRST, FN_FIND_LAST, FN_DEL_FIRST, FN_DEL_LAST: begin
              search <= 1'b1;
              back <= (c.func == FN_FIND_LAST || c.func == FN_DEL_LAST);
              p <= (c.func == FN_FIND_LAST || c.func == FN_DEL_LAST)
                   ? tail_ptr : head_ptr;
              idx <= (c.func == FN_FIND_LAST || c.func == FN_DEL_LAST)
                     ? item_count - 1'b1 : '0;
              mode <= (c.func >= FN_DEL_FIRST) ? 2'd1 : 2'd0;
              steps <= '0;
              if (item_count != '0) state <= S_RD;
            end
            FN_CLEAR: begin
              free_map <= '1; head_ptr <= Nil; tail_ptr <= Nil;
              item_count <= '0;
            end
            default: ;
          endcase
        end
        S_RD: begin
          // index walk: target reached, read it without the end-of-list check
          if (!search && idx == c.position) state <= S_WT;
          else if (p == Nil || (search && steps == PtrW'(Capacity))) state <= S_OUT;
          else state <= S_WT;
        end
        S_WT: state <= S_ACT;  // registered read data settles
        S_ACT: begin
          if (search && rval != c.data_value) begin
            p <= back ? rprev : rnext;
            idx <= back ? idx - 1'b1 : idx + 1'b1;
            steps <= steps + 1'b1;
            state <= S_RD;
          end else if (!search && idx != c.position && c.func >= FN_GET) begin
            p <= back ? rprev : rnext;
            idx <= back ? idx - 1'b1 : idx + 1'b1;
            state <= S_RD;
          end else begin
            if (search) begin
              r.found <= 1'b1; r.result_index <= idx[IdxW-1:0];
            end
            x <= p; pv <= rprev;
            nx <= (mode == 2'd2) ? {1'b0, newn} : rnext;
            state <= S_OUT;
            unique case (mode)
              2'd0: if (!search) r.result_value <= rval;  // find reports no value
              2'd3: begin
                r.result_value <= rval;
                wr.we_val <= 1'b1; wr.addr <= p[IdxW-1:0]; wr.val <= c.data_value;
              end
              2'd1: begin
                r.result_value <= rval;
                free_map[p[IdxW-1:0]] <= 1'b1;
                item_count <= item_count - 1'b1;
                if (rprev == Nil) head_ptr <= rnext;
                else begin
                  wr.we_next <= 1'b1; wr.addr <= rprev[IdxW-1:0]; wr.nxt <= rnext;
                end
                if (rnext == Nil) tail_ptr <= rprev;
                else state <= S_L1;  // fix prev of successor next
              end
              2'd2: begin
                // new node before p
                wr.we_val <= 1'b1; wr.we_next <= 1'b1; wr.we_prev <= 1'b1;
                wr.addr <= newn; wr.val <= c.data_value; wr.nxt <= p; wr.prv <= rprev;
                free_map[newn] <= 1'b0;
                item_count <= item_count + 1'b1;
                if (rprev == Nil) head_ptr <= {1'b0, newn};
                state <= S_L1;
              end
              default: ;
            endcase
          end
        end
        S_L1: begin
          state <= S_OUT;
          if (c.func == FN_PUSH_FRONT) begin
            wr.we_prev <= 1'b1; wr.addr <= x[IdxW-1:0]; wr.prv <= head_ptr;
          end else if (mode == 2'd2 && c.func == FN_INSERT) begin
            wr.we_prev <= 1'b1; wr.addr <= x[IdxW-1:0]; wr.prv <= nx;
            if (pv != Nil) state <= S_L2;
          end else begin
            wr.we_prev <= 1'b1; wr.addr <= nx[IdxW-1:0]; wr.prv <= pv;
          end
        end
        S_L2: begin
          state <= S_OUT;
          wr.we_next <= 1'b1;
          if (c.func == FN_INSERT) begin
            wr.addr <= pv[IdxW-1:0]; wr.nxt <= nx;
          end else begin
            wr.addr <= x[IdxW-1:0]; wr.nxt <= tail_ptr;
          end
        end
        S_OUT: begin
          done <= 1'b1;
          r.element_count <= item_count;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "bounded_linked_list_deque_assert.svh"

  `BLD_ASSERT_NOW(a_done_idle, rst, done, state == S_IDLE)
  `BLD_ASSERT_NOW(a_count_max, rst, 1'b1, item_count <= PtrW'(Capacity))
  `BLD_ASSERT_NOW(a_empty_nil, rst, item_count == '0, head_ptr == Nil && tail_ptr == Nil)
  `BLD_ASSERT_NEXT(a_start_busy, rst, start && !busy, busy)
endmodule
`default_nettype wire
